@@ rtl/ccal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous channel allocator package
// Shared sizes, command and status codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package ccal_pkg;

  // Number of channels (2..64)
  localparam int CHANNELS = 4;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int LEN_W    = 3;
  localparam int REL_W    = 2;
  localparam int STATUS_W = 2;

  // Width wide enough for start + length and for the channel count itself
  localparam int SUM_W = ((CH_IDX_W > LEN_W) ? CH_IDX_W : LEN_W) + 2;

  // Shortest run that reserve-run accepts
  localparam int MIN_RUN = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESERVE_ONE = 2'd0,
    CMD_RESERVE_RUN = 2'd1,
    CMD_RELEASE     = 2'd2
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_SHORT_RUN = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture a new transaction, rewind the scan
    logic step;    // advance the scan to the next start channel
    logic commit;  // write result registers and the reserved mask
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;    // current transaction has its answer
  } dp_stat_t;

endpackage

@@ rtl/ccal_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous channel allocator datapath
// Holds the reserved mask, scans start channels one per cycle and builds
// the result registers.
// ----------------------------------------------------------------------------
module ccal_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ccal_pkg::dp_cmd_t              cmd,
  output ccal_pkg::dp_stat_t             stat,
  input  logic [ccal_pkg::CMD_W-1:0]     in_command,
  input  logic [ccal_pkg::LEN_W-1:0]     in_run_length,
  input  logic [ccal_pkg::REL_W-1:0]     in_release_index,
  output logic [ccal_pkg::STATUS_W-1:0]  out_status,
  output logic [ccal_pkg::CH_IDX_W-1:0]  out_first_channel,
  output logic [ccal_pkg::CHANNELS-1:0]  out_reserved_now
);

  // Captured transaction and scan position
  logic [ccal_pkg::CMD_W-1:0]    cmd_r;
  logic [ccal_pkg::LEN_W-1:0]    len_r;
  logic [ccal_pkg::REL_W-1:0]    idx_r;
  logic [ccal_pkg::CH_IDX_W-1:0] pos_r;
  logic [ccal_pkg::CHANNELS-1:0] mask_r;

  // Result registers
  logic [ccal_pkg::STATUS_W-1:0] status_r;
  logic [ccal_pkg::CH_IDX_W-1:0] first_r;

  logic                          search_op;
  logic [ccal_pkg::LEN_W-1:0]    eff_len;
  logic [ccal_pkg::SUM_W-1:0]    pos_ext;
  logic [ccal_pkg::SUM_W-1:0]    end_ext;
  logic [ccal_pkg::CHANNELS-1:0] window;
  logic                          fits;
  logic                          hit;
  logic                          pos_last;

  logic [ccal_pkg::STATUS_W-1:0] status_nxt;
  logic [ccal_pkg::CH_IDX_W-1:0] first_nxt;
  logic [ccal_pkg::CHANNELS-1:0] mask_nxt;

  // Decode: which commands search, and how wide the window is
  always_comb begin
    search_op = 1'b0;
    eff_len   = ccal_pkg::LEN_W'(1);
    case (cmd_r)
      ccal_pkg::CMD_RESERVE_ONE: begin
        search_op = 1'b1;
      end
      ccal_pkg::CMD_RESERVE_RUN: begin
        search_op = (len_r >= ccal_pkg::LEN_W'(ccal_pkg::MIN_RUN));
        eff_len   = len_r;
      end
      default: begin
        search_op = 1'b0;
      end
    endcase
  end

  // Window of eff_len channels starting at pos_r
  assign pos_ext = ccal_pkg::SUM_W'(pos_r);
  assign end_ext = pos_ext + ccal_pkg::SUM_W'(eff_len);

  always_comb begin
    for (int i = 0; i < ccal_pkg::CHANNELS; i++) begin
      window[i] = (ccal_pkg::SUM_W'(i) >= pos_ext) && (ccal_pkg::SUM_W'(i) < end_ext);
    end
  end

  assign fits     = (end_ext <= ccal_pkg::SUM_W'(ccal_pkg::CHANNELS)) &&
                    ((mask_r & window) == '0);
  assign hit      = search_op && fits;
  assign pos_last = (pos_r == ccal_pkg::CH_IDX_W'(ccal_pkg::CHANNELS - 1));

  assign stat.done = !search_op || hit || pos_last;

  // Result and mask update for the commit
  always_comb begin
    status_nxt = ccal_pkg::ST_DONE;
    first_nxt  = '0;
    mask_nxt   = mask_r;
    if (search_op) begin
      if (hit) begin
        first_nxt = pos_r;
        mask_nxt  = mask_r | window;
      end else begin
        status_nxt = ccal_pkg::ST_NO_FREE;
      end
    end else begin
      case (cmd_r)
        ccal_pkg::CMD_RESERVE_RUN: begin
          status_nxt = ccal_pkg::ST_SHORT_RUN;
        end
        ccal_pkg::CMD_RELEASE: begin
          for (int i = 0; i < ccal_pkg::CHANNELS; i++) begin
            if (ccal_pkg::SUM_W'(idx_r) == ccal_pkg::SUM_W'(i)) begin
              mask_nxt[i] = 1'b0;
            end
          end
        end
        default: begin
          mask_nxt = mask_r;
        end
      endcase
    end
  end

  // Reserved mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cmd.commit) begin
      mask_r <= mask_nxt;
    end
  end

  // Transaction capture and scan position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      len_r <= in_run_length;
      idx_r <= in_release_index;
      pos_r <= '0;
    end else if (cmd.step) begin
      pos_r <= pos_r + ccal_pkg::CH_IDX_W'(1);
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_nxt;
      first_r  <= first_nxt;
    end
  end

  assign out_status        = status_r;
  assign out_first_channel = first_r;
  assign out_reserved_now  = mask_r;

endmodule

@@ rtl/ccal_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous channel allocator controller
// Sequences accept, scan and commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module ccal_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output ccal_pkg::dp_cmd_t  cmd,
  input  ccal_pkg::dp_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Result slot is free when empty or being taken this cycle
  assign out_free = !out_valid_r || out_ready;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.done) begin
          if (out_free) begin
            cmd.commit = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.commit || (out_valid_r && !out_ready);
  end

  // State and registered valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/contiguous_channel_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous channel allocator
// First-fit allocator of single channels and runs of adjacent channels over
// a per-channel reserved mask, with channel release.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in_      | in_valid / in_ready  | command, run_length, release_index
//  out_     | out_valid / out_ready| status, first_channel, reserved_now
//
//  One transaction at a time. After acceptance the datapath tests one start
//  channel per cycle and stops at the first fit or at the last channel; release
//  and rejected commands finish without a scan. in_ready is high only when
//  the sequencer is idle, and a finished result waits in the output register
//  while the next transaction is accepted and scanned. Synchronous reset
//  clears the reserved mask and the output valid flag.
// ----------------------------------------------------------------------------
module contiguous_channel_allocator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ccal_pkg::CMD_W-1:0]     in_command,
  input  logic [ccal_pkg::LEN_W-1:0]     in_run_length,
  input  logic [ccal_pkg::REL_W-1:0]     in_release_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ccal_pkg::STATUS_W-1:0]  out_status,
  output logic [ccal_pkg::CH_IDX_W-1:0]  out_first_channel,
  output logic [ccal_pkg::CHANNELS-1:0]  out_reserved_now
);

  ccal_pkg::dp_cmd_t  dp_cmd;
  ccal_pkg::dp_stat_t dp_stat;

  ccal_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  ccal_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .stat              (dp_stat),
    .in_command        (in_command),
    .in_run_length     (in_run_length),
    .in_release_index  (in_release_index),
    .out_status        (out_status),
    .out_first_channel (out_first_channel),
    .out_reserved_now  (out_reserved_now)
  );

  // Not ready in the cycle after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted transaction");

  // A commit always presents a result next cycle
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.commit |=> out_valid)
    else $error("commit did not raise out_valid");

  // Failed or rejected commands grant no channel
  a_fail_no_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ccal_pkg::ST_DONE) |-> out_first_channel == '0)
    else $error("nonzero first_channel on a failed command");

  // Mask moves only on a commit
  a_mask_commit_only: assert property (@(posedge clk) disable iff (!rst_n)
    !dp_cmd.commit |=> $stable(out_reserved_now))
    else $error("reserved mask changed without a commit");

endmodule

@@ sim/contiguous_channel_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous channel allocator testbench
// Drives reserve-one, reserve-run, release and unused commands through the
// valid/ready input channel. A shadow copy of the reserved mask predicts each
// result at acceptance, and a checker compares every returned transaction
// field by field, in order. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module contiguous_channel_allocator_unit_tb;

  // Command code with no function in the block
  localparam logic [ccal_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1200;
  localparam int IDLE_LIMIT   = 500;
  localparam int TAIL_CYCLES  = 4 * ccal_pkg::CHANNELS;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    ccal_pkg::status_t                 status;
    logic [ccal_pkg::CH_IDX_W-1:0]     first;
    logic [ccal_pkg::CHANNELS-1:0]     mask;
  } grant_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [ccal_pkg::CMD_W-1:0]      in_command = '0;
  logic [ccal_pkg::LEN_W-1:0]      in_run_length = '0;
  logic [ccal_pkg::REL_W-1:0]      in_release_index = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [ccal_pkg::STATUS_W-1:0]   out_status;
  logic [ccal_pkg::CH_IDX_W-1:0]   out_first_channel;
  logic [ccal_pkg::CHANNELS-1:0]   out_reserved_now;

  logic [ccal_pkg::CHANNELS-1:0]   shadow_reserved = '0;
  grant_result_t                   pending_grants[$];
  int                              mismatch_count = 0;
  int                              result_count = 0;
  int                              idle_cycles = 0;
  int                              send_gap_max = 4;
  int                              recv_stall_max = 4;

  contiguous_channel_allocator_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_run_length     (in_run_length),
    .in_release_index  (in_release_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_first_channel (out_first_channel),
    .out_reserved_now  (out_reserved_now)
  );

  always #1 clk = ~clk;

  // Applies one command to the shadow mask and returns the expected result
  function automatic grant_result_t predict_grant(
    input logic [ccal_pkg::CMD_W-1:0] cmd,
    input logic [ccal_pkg::LEN_W-1:0] len,
    input logic [ccal_pkg::REL_W-1:0] idx);
    grant_result_t                 r;
    logic [ccal_pkg::CHANNELS-1:0] want;
    logic                          found;
    r.status = ccal_pkg::ST_DONE;
    r.first  = '0;
    found    = 1'b0;
    if (cmd == ccal_pkg::CMD_RESERVE_ONE) begin
      for (int c = 0; c < ccal_pkg::CHANNELS && !found; c++) begin
        if (!shadow_reserved[c]) begin
          shadow_reserved[c] = 1'b1;
          r.first = ccal_pkg::CH_IDX_W'(c);
          found = 1'b1;
        end
      end
      if (!found) r.status = ccal_pkg::ST_NO_FREE;
    end else if (cmd == ccal_pkg::CMD_RESERVE_RUN) begin
      if (int'(len) < ccal_pkg::MIN_RUN) begin
        r.status = ccal_pkg::ST_SHORT_RUN;
      end else begin
        // first fit: lowest start whose whole window is free
        for (int s = 0; s + int'(len) <= ccal_pkg::CHANNELS && !found; s++) begin
          want = '0;
          for (int b = 0; b < int'(len); b++) want[s + b] = 1'b1;
          if ((shadow_reserved & want) == '0) begin
            shadow_reserved |= want;
            r.first = ccal_pkg::CH_IDX_W'(s);
            found = 1'b1;
          end
        end
        if (!found) r.status = ccal_pkg::ST_NO_FREE;
      end
    end else if (cmd == ccal_pkg::CMD_RELEASE) begin
      if (int'(idx) < ccal_pkg::CHANNELS) shadow_reserved[idx] = 1'b0;
    end
    r.mask = shadow_reserved;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Sends one transaction after a random gap; predicts on acceptance
  task automatic send_request(input logic [ccal_pkg::CMD_W-1:0] cmd,
                              input logic [ccal_pkg::LEN_W-1:0] len,
                              input logic [ccal_pkg::REL_W-1:0] idx);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_run_length    <= len;
    in_release_index <= idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_grants.push_back(predict_grant(cmd, len, idx));
  endtask

  // Result side: random stalls, in-order compare against predictions
  initial begin : result_checker
    grant_result_t want;
    int            stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(0, recv_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      result_count++;
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("result %0d with no transaction pending", result_count));
      end else begin
        want = pending_grants.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                                    result_count, out_status, want.status));
        if (out_first_channel !== want.first)
          report_mismatch($sformatf("result %0d first_channel %0d, want %0d",
                                    result_count, out_first_channel, want.first));
        if (out_reserved_now !== want.mask)
          report_mismatch($sformatf("result %0d reserved_now %b, want %b",
                                    result_count, out_reserved_now, want.mask));
      end
    end
  end

  // Watchdog: consecutive cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("contiguous_channel_allocator_unit_tb: done, errors");
    $finish;
  end

  // Fill every channel one at a time, then one more with none free
  task automatic test_single_grants();
    repeat (ccal_pkg::CHANNELS + 1) send_request(ccal_pkg::CMD_RESERVE_ONE, '0, '0);
  endtask

  // Release from a full mask, including a channel that is already free
  task automatic test_releases();
    send_request(ccal_pkg::CMD_RELEASE, 3'd0, 2'd2);
    send_request(ccal_pkg::CMD_RELEASE, 3'd7, 2'd2);
    send_request(ccal_pkg::CMD_RELEASE, 3'd0, 2'd0);
    send_request(ccal_pkg::CMD_RELEASE, 3'd0, 2'd1);
    send_request(ccal_pkg::CMD_RELEASE, 3'd0, 2'd3);
  endtask

  // Runs: too short, full width, blocked, gap-fitting and oversized
  task automatic test_run_grants();
    send_request(ccal_pkg::CMD_RESERVE_RUN, 3'd0, 2'd3);
    send_request(ccal_pkg::CMD_RESERVE_RUN, 3'd1, 2'd3);
    send_request(ccal_pkg::CMD_RESERVE_RUN, 3'd4, 2'd0);
    send_request(ccal_pkg::CMD_RESERVE_RUN, 3'd2, 2'd0);
    send_request(ccal_pkg::CMD_RELEASE,     3'd0, 2'd1);
    send_request(ccal_pkg::CMD_RESERVE_RUN, 3'd2, 2'd0);
    send_request(ccal_pkg::CMD_RELEASE,     3'd0, 2'd2);
    send_request(ccal_pkg::CMD_RESERVE_RUN, 3'd2, 2'd0);
    send_request(ccal_pkg::CMD_RELEASE,     3'd0, 2'd0);
    send_request(ccal_pkg::CMD_RELEASE,     3'd0, 2'd3);
    send_request(ccal_pkg::CMD_RESERVE_RUN, 3'd3, 2'd0);
    send_request(ccal_pkg::CMD_RESERVE_RUN, 3'd7, 2'd0);
    send_request(ccal_pkg::CMD_RELEASE,     3'd0, 2'd1);
    send_request(ccal_pkg::CMD_RELEASE,     3'd0, 2'd2);
    send_request(ccal_pkg::CMD_RESERVE_RUN, 3'd3, 2'd0);
    send_request(ccal_pkg::CMD_RESERVE_RUN, 3'd2, 2'd0);
    send_request(ccal_pkg::CMD_RESERVE_ONE, 3'd0, 2'd0);
  endtask

  // Command code three must leave the mask alone
  task automatic test_unused_command();
    send_request(CMD_UNUSED, 3'd7, 2'd3);
    send_request(CMD_UNUSED, 3'd0, 2'd0);
  endtask

  // Mixed traffic that keeps the mask partly full
  task automatic test_random_traffic();
    int                              counted;
    int                              pick;
    logic [ccal_pkg::CMD_W-1:0]      cmd;
    logic [ccal_pkg::LEN_W-1:0]      len;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      len  = ccal_pkg::LEN_W'($urandom_range(0, 7));
      if (pick < 30) begin
        cmd = ccal_pkg::CMD_RESERVE_ONE;
      end else if (pick < 60) begin
        cmd = ccal_pkg::CMD_RESERVE_RUN;
        if ($urandom_range(0, 9) != 0)
          len = ccal_pkg::LEN_W'($urandom_range(ccal_pkg::MIN_RUN, ccal_pkg::CHANNELS));
      end else if (pick < 95) begin
        cmd = ccal_pkg::CMD_RELEASE;
      end else begin
        cmd = CMD_UNUSED;
      end
      send_request(cmd, len, ccal_pkg::REL_W'($urandom_range(0, 3)));
      if (cmd != CMD_UNUSED) counted++;
    end
  endtask

  initial begin : sequencer
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_grants();
    test_releases();
    test_run_grants();
    test_unused_command();
    test_random_traffic();
    in_valid <= 1'b0;
    wait (pending_grants.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("contiguous_channel_allocator_unit_tb: done, clean");
    end else begin
      $display("contiguous_channel_allocator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ contiguous_channel_allocator_unit.f @@
rtl/ccal_pkg.sv
rtl/ccal_datapath.sv
rtl/ccal_controller.sv
rtl/contiguous_channel_allocator_unit.sv
sim/contiguous_channel_allocator_unit_tb.sv
